[hdl/gsb_pkg.sv]
// Package for the sprite sort-and-batch block: sort modes, sequencer states
// and the sort key mapping. No dependencies.
package gsb_pkg;

    localparam int unsigned VERTS_PER_SPRITE = 6;
    localparam int unsigned KEY_W            = 16;

    typedef enum logic [1:0] {
        MODE_KEEP       = 2'd0,
        MODE_DEPTH_DESC = 2'd1,
        MODE_DEPTH_ASC  = 2'd2,
        MODE_TEX_ASC    = 2'd3
    } t_sort_mode;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Maps the mode's key onto an unsigned value that ascends in output order.
    function automatic logic [KEY_W-1:0] sort_key(
        input t_sort_mode       mode,
        input logic [KEY_W-1:0] depth,
        input logic [KEY_W-1:0] tex
    );
        logic [KEY_W-1:0] k;
        begin
            unique case (mode)
                MODE_KEEP:       k = '0;
                MODE_DEPTH_DESC: k = ~(depth ^ 16'h8000);
                MODE_DEPTH_ASC:  k = depth ^ 16'h8000;
                MODE_TEX_ASC:    k = tex;
                default:         k = '0;
            endcase
            return k;
        end
    endfunction

endpackage

[hdl/gsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/glyph_sort_and_batch_top.sv]
// Sprite sort-and-batch top level. Uses gsb_pkg and one gsb_ram instance for
// the sprite store (depth and texture, addressed by arrival position).
//
// Loading takes one sprite item per cycle. A frame-end item starts the sort:
// for each output position the single compare unit scans all n stored
// sprites through the store's read port, picking the smallest {key, arrival}
// above the one emitted before, so the order is stable. Each result takes a
// full scan of the n stored sprites plus any output stall; no input is taken
// until the last result of the frame has been delivered. An empty frame end
// gives no result. Sprites beyond MAX_SPRITES are dropped and the frame's
// results carry the overflow flag.
module glyph_sort_and_batch_top #(
    parameter int MAX_SPRITES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: sort_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    // sprite items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] depth, [31:16] texture_id
    input  logic        s_axis_tuser,   // [0] frame_end
    // sorted results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] sprite_index, [21:6] texture_id_out,
                                        // [30:22] vertex_offset, [31] zero
    output logic [1:0]  m_axis_tuser,   // [0] batch_start, [1] overflow
    output logic        m_axis_tlast    // last_sprite
);

    import gsb_pkg::*;

    localparam int AW   = $clog2(MAX_SPRITES);
    localparam int CW   = $clog2(MAX_SPRITES + 1);
    localparam int CMPW = KEY_W + AW;

    t_state            r_state, n_state;
    t_sort_mode        r_sort_mode;
    logic [CW-1:0]     r_count;
    logic              r_dropped;
    logic [CW-1:0]     r_issue;
    logic              r_q_v;
    logic [AW-1:0]     r_q_idx;
    logic              r_best_v;
    logic [CMPW-1:0]   r_best;
    logic [KEY_W-1:0]  r_best_tex;
    logic              r_have_last;
    logic [CMPW-1:0]   r_last;
    logic [KEY_W-1:0]  r_prev_tex;
    logic [AW-1:0]     r_pos;

    logic              in_acc, out_acc, frame_end;
    logic              ram_we;
    logic [31:0]       ram_q;
    logic [CMPW-1:0]   cand;
    logic              cand_ok;
    logic              scan_done, is_last;
    logic [AW-1:0]     best_idx;
    logic [8:0]        vertex_offset;
    logic              batch_start;

    assign frame_end = s_axis_tuser;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign ram_we    = in_acc && !frame_end && (r_count < CW'(MAX_SPRITES));

    gsb_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SPRITES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_q)
    );

    // shared compare unit: candidate must lie above the last emitted one
    // and below the best found so far in this pass
    assign cand    = {sort_key(r_sort_mode, ram_q[15:0], ram_q[31:16]), r_q_idx};
    assign cand_ok = r_q_v && (!r_have_last || cand > r_last)
                     && (!r_best_v || cand < r_best);

    assign scan_done = (r_issue == r_count) && !r_q_v;
    assign is_last   = (CW'(r_pos) + CW'(1)) == r_count;
    assign best_idx  = r_best[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && frame_end && r_count != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    n_state = is_last ? ST_LOAD : ST_SCAN;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_LOAD: s_axis_tready = 1'b1;
            ST_SCAN: ;
            ST_EMIT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_sort_mode <= MODE_KEEP;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_issue     <= '0;
            r_q_v       <= 1'b0;
            r_best_v    <= 1'b0;
            r_have_last <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_sort_mode <= t_sort_mode'(i_cfg_data);
            end
            unique case (r_state)
                ST_LOAD: begin
                    r_issue     <= '0;
                    r_q_v       <= 1'b0;
                    r_best_v    <= 1'b0;
                    r_have_last <= 1'b0;
                    r_pos       <= '0;
                    if (in_acc) begin
                        if (frame_end) begin
                            if (r_count == '0) begin
                                r_dropped <= 1'b0;
                            end
                        end else if (r_count < CW'(MAX_SPRITES)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_q_v <= (r_issue != r_count);
                    if (r_issue != r_count) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    r_q_idx <= r_issue[AW-1:0];
                    if (cand_ok) begin
                        r_best_v   <= 1'b1;
                        r_best     <= cand;
                        r_best_tex <= ram_q[31:16];
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_have_last <= 1'b1;
                        r_last      <= r_best;
                        r_prev_tex  <= r_best_tex;
                        r_pos       <= r_pos + AW'(1);
                        r_issue     <= '0;
                        r_best_v    <= 1'b0;
                        if (is_last) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign vertex_offset = 9'(r_pos) * 9'(VERTS_PER_SPRITE);
    assign batch_start   = (r_pos == '0) || (r_best_tex != r_prev_tex);

    assign m_axis_tdata = {1'b0, vertex_offset, r_best_tex, 6'(best_idx)};
    assign m_axis_tuser = {r_dropped, batch_start};
    assign m_axis_tlast = is_last;

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result is pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SPRITES))
        else $error("sprite count beyond capacity");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (r_count == '0 && !r_dropped && s_axis_tready))
        else $error("frame state not cleared after last result");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_best_v && CW'(r_pos) < r_count))
        else $error("result emitted without a selected sprite");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for glyph_sort_and_batch_top: a directed table, then random sprite frames,
// with the results checked against a stable-sort predictor held here.
// Depends on gsb_pkg and the block's RTL only.
module tb_top;
    import gsb_pkg::*;

    localparam int MAX_SPRITES   = 64;
    localparam int RAND_ITEMS    = 180;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500_000;

    typedef enum logic [1:0] {
        ROW_SPRITE,
        ROW_END,
        ROW_MODE
    } t_row_kind;

    // one sorted sprite, holding the fields that tdata/tuser/tlast carry
    typedef struct packed {
        logic       ovf;
        logic       last;
        logic       batch;
        logic [8:0] vtx;
        logic [15:0] tex;
        logic [5:0] idx;
    } t_sprite_out;

    typedef struct {
        t_row_kind   kind;
        logic [15:0] depth;
        logic [15:0] tex;
        t_sort_mode  mode;
        bit          typed;
        t_sprite_out want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;   // [15:0] depth, [31:16] texture_id
    logic        s_axis_tuser = 1'b0;    // [0] frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [5:0] index, [21:6] texture, [30:22] vertex, [31] 0
    logic [1:0]  m_axis_tuser;           // [0] batch_start, [1] overflow
    logic        m_axis_tlast;           // last_sprite

    glyph_sort_and_batch_top #(.MAX_SPRITES(MAX_SPRITES)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // frame store as the predictor sees it
    logic [15:0]  frame_depth [MAX_SPRITES];
    logic [15:0]  frame_tex   [MAX_SPRITES];
    int           frame_count = 0;
    bit           frame_overflow = 1'b0;
    t_sort_mode   cur_mode = MODE_KEEP;
    t_sprite_out  pending_sprites [$];
    t_dir_row     script [$];
    int           errors = 0;
    int           sent = 0;
    int           cycles = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int           rx_stall = 0;
    t_sprite_out  want_out;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int tx_gap();
        if (tx_calm)
            return 0;
        if ($urandom_range(0, 99) < 35)
            return pick_gap();
        return 0;
    endfunction

    function automatic logic [15:0] pick_depth();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'hFFFF;
                    2:       return 16'h0000;
                    3:       return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            end
            3, 4:    return 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_tex();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 3));
            4:          return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:    return 16'($urandom);
        endcase
    endfunction

    // strict order only, so equal keys keep arrival order
    function automatic bit goes_ahead(int a, int b);
        case (cur_mode)
            MODE_DEPTH_DESC: return $signed(frame_depth[a]) > $signed(frame_depth[b]);
            MODE_DEPTH_ASC:  return $signed(frame_depth[a]) < $signed(frame_depth[b]);
            MODE_TEX_ASC:    return frame_tex[a] < frame_tex[b];
            default:         return 1'b0;
        endcase
    endfunction

    task automatic track_item(input bit is_end, input logic [15:0] d, input logic [15:0] t,
                              input bit emit);
        int          order [MAX_SPRITES];
        int          n;
        int          j;
        t_sprite_out r;
        logic [15:0] prev_tex;
        prev_tex = '0;
        if (!is_end) begin
            if (frame_count < MAX_SPRITES) begin
                frame_depth[frame_count] = d;
                frame_tex[frame_count]   = t;
                frame_count++;
            end else begin
                frame_overflow = 1'b1;
            end
            return;
        end
        n = frame_count;
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && goes_ahead(i, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < n; i++) begin
            r.idx    = 6'(order[i]);
            r.tex    = frame_tex[order[i]];
            r.vtx    = 9'(VERTS_PER_SPRITE * i);
            r.batch  = (i == 0) || (r.tex != prev_tex);
            r.last   = (i == n - 1);
            r.ovf    = frame_overflow;
            prev_tex = r.tex;
            if (emit)
                pending_sprites.push_back(r);
        end
        frame_count    = 0;
        frame_overflow = 1'b0;
    endtask

    task automatic send_item(input bit is_end, input logic [15:0] d, input logic [15:0] t,
                             input int gap, input bit typed, input t_sprite_out want);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {t, d};
        s_axis_tuser  = is_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_item(is_end, d, t, !typed);
        if (typed && is_end)
            pending_sprites.push_back(want);
        sent++;
    endtask

    // wait until the block has drained and is back to loading
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_sprites.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_sort_mode m);
        settle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_mode = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 2'($urandom);
    endtask

    task automatic add_row(input t_row_kind k, input logic [15:0] d, input logic [15:0] t,
                           input t_sort_mode m);
        script.push_back('{k, d, t, m, 1'b0, '0});
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure: short stalls mostly, some long, calm stretches too
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            rx_calm = !rx_calm;
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 9) < 3) begin
            rx_stall = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sprites.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected item, expected none, got tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want_out = pending_sprites.pop_front();
                check_field("sprite_index", want_out.idx, m_axis_tdata[5:0]);
                check_field("texture_id", want_out.tex, m_axis_tdata[21:6]);
                check_field("vertex_offset", want_out.vtx, m_axis_tdata[30:22]);
                check_field("tdata pad", 0, m_axis_tdata[31]);
                check_field("batch_start", want_out.batch, m_axis_tuser[0]);
                check_field("overflow", want_out.ovf, m_axis_tuser[1]);
                check_field("last_sprite", want_out.last, m_axis_tlast);
            end
        end
    end

    initial begin : stimulus
        int          size;
        int          roll;
        int          big_at;
        int          frame_no;
        int          phase;
        int          frames;
        t_sort_mode  m;

        // after reset, keep order: empty frame with junk fields, then one sprite
        add_row(ROW_END, 16'h1234, 16'hABCD, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h8000, 16'hFFFF, MODE_KEEP);
        script.push_back('{ROW_END, 16'h5A5A, 16'hA5A5, MODE_KEEP, 1'b1,
                           '{1'b0, 1'b1, 1'b1, 9'd0, 16'hFFFF, 6'd0}});
        // depth descending, extremes and a tie
        add_row(ROW_MODE, 16'h0, 16'h0, MODE_DEPTH_DESC);
        add_row(ROW_SPRITE, 16'h7FFF, 16'h0000, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h8000, 16'h0000, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0000, 16'h0001, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h7FFF, 16'h0001, MODE_KEEP);
        add_row(ROW_SPRITE, 16'hFFFF, 16'h0000, MODE_KEEP);
        add_row(ROW_END, 16'hFFFF, 16'hFFFF, MODE_KEEP);
        // depth ascending
        add_row(ROW_MODE, 16'h0, 16'h0, MODE_DEPTH_ASC);
        add_row(ROW_SPRITE, 16'h8000, 16'h0005, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h7FFF, 16'h0005, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h8000, 16'h0005, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0001, 16'h0007, MODE_KEEP);
        add_row(ROW_END, 16'h0000, 16'h0000, MODE_KEEP);
        // texture ascending
        add_row(ROW_MODE, 16'h0, 16'h0, MODE_TEX_ASC);
        add_row(ROW_SPRITE, 16'h0100, 16'hFFFF, MODE_KEEP);
        add_row(ROW_SPRITE, 16'hFF00, 16'h0000, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0000, 16'hFFFF, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h7FFF, 16'h8000, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h8000, 16'h0000, MODE_KEEP);
        add_row(ROW_END, 16'hAAAA, 16'h5555, MODE_KEEP);
        // back to arrival order, texture runs
        add_row(ROW_MODE, 16'h0, 16'h0, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0003, 16'h0003, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0002, 16'h0003, MODE_KEEP);
        add_row(ROW_SPRITE, 16'h0001, 16'h0004, MODE_KEEP);
        add_row(ROW_END, 16'h0000, 16'h0000, MODE_KEEP);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_MODE)
                write_mode(script[r].mode);
            else
                send_item(script[r].kind == ROW_END, script[r].depth, script[r].tex,
                          tx_gap(), script[r].typed, script[r].want);
        end

        // random frames; one frame runs past the store's capacity
        sent     = 0;
        frame_no = 0;
        phase    = 0;
        big_at   = $urandom_range(2, 6);
        while (sent < RAND_ITEMS) begin
            m = (phase < 4) ? t_sort_mode'(3 - phase) : t_sort_mode'($urandom_range(0, 3));
            write_mode(m);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                if (frame_no == big_at) begin
                    size = MAX_SPRITES + $urandom_range(1, 4);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        size = 0;
                    else if (roll < 70)
                        size = $urandom_range(1, 6);
                    else if (roll < 95)
                        size = $urandom_range(7, 16);
                    else
                        size = $urandom_range(17, 40);
                end
                for (int k = 0; k < size; k++)
                    send_item(1'b0, pick_depth(), pick_tex(), tx_gap(), 1'b0, '0);
                send_item(1'b1, 16'($urandom), 16'($urandom), tx_gap(), 1'b0, '0);
                frame_no++;
            end
            phase++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
